/* hdl/autocorrelation_diffusion_stats_defines.svh */
// Assertion macros used by the checker of the autocorrelation block.
`ifndef AUTOCORRELATION_DIFFUSION_STATS_DEFINES_SVH
`define AUTOCORRELATION_DIFFUSION_STATS_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define ADSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ADSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/adsp_pkg.sv */
// Shared types, constants and a helper function of the autocorrelation block.
`timescale 1ns / 1ps
package adsp_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 16384;
  localparam int unsigned MAX_LAGS_DEF    = 8192;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned LAG_W      = 13;
  localparam int unsigned LAGCNT_W   = 14;
  localparam int unsigned TS_W       = 16;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 208;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LAGCNT_W-1:0] LAG_COUNT_RST = 14'd6000;
  localparam logic [TS_W-1:0]     TIMESTEP_RST  = 16'd512;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_COMPUTE = 2'd1,
    FUNC_READ    = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_SAMPLES = 2'd1,
    STAT_LAG_RANGE  = 2'd2,
    STAT_SATURATED  = 2'd3
  } status_t;

  typedef enum logic {
    KIND_STATS = 1'b0,
    KIND_CORR  = 1'b1
  } kind_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LAG_COUNT = 1'b0,
    REG_TIMESTEP  = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_RES, S_NOSAMP, S_SUM_SCAN, S_MEAN_DIV, S_MEAN_TAKE, S_LAG_TEST,
    S_LAG_SCAN, S_LAG_DIV, S_LAG_TAKE, S_LAG_FIN, S_TRAP, S_LAG_NEXT, S_STATS_RES
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_issue;
    logic start_compute;
    logic scan_start;
    logic scan_sum;
    logic div_start;
    logic take_mean;
    logic take_lag;
    logic lag_fin;
    logic next_lag;
    logic res_read;
    logic res_nosamp;
    logic res_stats;
  } dp_cmd_t;

  typedef struct packed {
    logic no_samples;
    logic has_pairs;
    logic lags_done;
    logic scan_busy;
    logic div_busy;
    logic trap_busy;
    logic slot_free;
  } dp_stat_t;

  typedef struct packed {
    logic              ovf;
    logic signed [63:0] val;
  } sat64_t;

  // Signed 64-bit add that clamps to the range and reports the clamp.
  function automatic sat64_t sat_add64(logic signed [63:0] a, logic signed [63:0] b);
    logic [64:0] s;
    sat64_t      r;
    s = {a[63], a} + {b[63], b};
    r.ovf = s[64] ^ s[63];
    if (r.ovf) begin
      r.val = s[64] ? S64_MIN : S64_MAX;
    end else begin
      r.val = s[63:0];
    end
    return r;
  endfunction

endpackage

/* hdl/autocorrelation_diffusion_stats.sv */
// Top level of the unbiased autocorrelation and diffusion statistics block.
`timescale 1ns / 1ps
// Samples (signed Q16.16) are appended with load transactions, one per cycle,
// up to MAX_SAMPLES; further loads are dropped. A compute transaction sums the
// stored samples, divides for the mean, then runs one pass per lag t below
// lag_count, capped at MAX_LAGS (lag 0 runs even for a lag_count of 0): a
// single multiply-accumulate pipe reads deviation pairs d[i]*d[i+t] from two
// identical copies of the sample memory, one pair per cycle, and a serial
// divider forms the unbiased value sum/(N-t). The lag-0 pass also yields the
// variance, and each finished lag feeds a small trapezoid integrator. A read
// transaction returns one stored lag value through the registered lag store
// read and the output register. No input is taken while a compute or a read is
// in progress, but loads keep flowing while a result waits in the output register.
// Reading a lag that no compute has written returns an undefined value. No
// clearing pass is needed after reset.
module autocorrelation_diffusion_stats
  import adsp_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int unsigned MAX_LAGS    = MAX_LAGS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sample[31:0], lag_index[44:32], zero pad
  input  logic [FUNC_W-1:0]     in_tuser,   // func[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // lag_echo, correlation, variance_out,
                                            // integral, status, zero pad
  output logic                  out_tuser,  // kind
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller only decides what happens; every stored value lives in
  // the datapath.
  adsp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .stat(stat), .cmd(cmd)
  );

  adsp_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_LAGS(MAX_LAGS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_sample(in_tdata[SAMPLE_W-1:0]),
    .in_lag_index(in_tdata[SAMPLE_W+LAG_W-1:SAMPLE_W]),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule

/* hdl/adsp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module adsp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/adsp_div.sv */
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating.
`timescale 1ns / 1ps
module adsp_div #(
  parameter int unsigned DW = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic [DW-1:0]      divisor,
  output logic               busy,
  output logic signed [63:0] quotient
);

  logic          busy_r, busy_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic [63:0]   quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;

  assign shifted = {rem_r, quo_r[63]};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'd64;
      neg_nxt  = dividend[63];
      quo_nxt  = dividend[63] ? (64'd0 - dividend) : dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        rem_nxt = diff[DW-1:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted[DW-1:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? (64'sd0 - $signed(quo_r)) : $signed(quo_r);

endmodule

/* hdl/adsp_datapath.sv */
// Datapath: sample and lag stores, multiply-accumulate pipe, divider, integrator.
`timescale 1ns / 1ps
module adsp_datapath
  import adsp_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int unsigned MAX_LAGS    = MAX_LAGS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic [SAMPLE_W-1:0]     in_sample,
  input  logic [LAG_W-1:0]        in_lag_index,
  input  logic                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_DATA_W-1:0]   out_tdata,
  output logic                    out_tuser
);

  localparam int unsigned SAW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned LAW = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;
  localparam int unsigned TW  = $clog2(MAX_LAGS + 1);

  // Configuration
  logic [LAGCNT_W-1:0] lag_count_r;
  logic [TS_W-1:0]     timestep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_count_r <= LAG_COUNT_RST;
      timestep_r  <= TIMESTEP_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_LAG_COUNT: lag_count_r <= cfg_wdata[LAGCNT_W-1:0];
        REG_TIMESTEP:  timestep_r  <= cfg_wdata[TS_W-1:0];
      endcase
    end
  end

  // Control state shared across one compute
  logic [CW-1:0]       count_r;
  logic [TW-1:0]       t_r;
  logic                sat_r, sat_nxt;
  logic signed [31:0]  mean_r;
  logic signed [63:0]  cval_r, prev_r, var_r, integ_r, acc_r;
  logic [LAG_W-1:0]    lag_r;

  logic [TW-1:0] nl, nl_lim;
  logic          has_pairs, wr_ok, in_range, store_full;

  always_comb begin
    if (32'(lag_count_r) < MAX_LAGS) begin
      nl = TW'(lag_count_r);
    end else begin
      nl = TW'(MAX_LAGS);
    end
    nl_lim = (nl == '0) ? TW'(1) : nl;
  end

  assign has_pairs  = 32'(t_r) < 32'(count_r);
  assign wr_ok      = t_r < nl;
  assign in_range   = 32'(lag_r) < 32'(nl);
  assign store_full = 32'(count_r) >= MAX_SAMPLES;

  // Sample stores: two identical copies give two read ports
  logic          scanning_r, scan_sum_r;
  logic [CW-1:0] i_r, limit_r;
  logic [CW-1:0] addr_b_full;
  logic [31:0]   rd_a, rd_b;
  logic          ld_we;

  assign ld_we       = cmd.load && !store_full;
  assign addr_b_full = i_r + CW'(t_r);

  adsp_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_store_a (
    .clk(clk), .we(ld_we), .waddr(count_r[SAW-1:0]), .wdata(in_sample),
    .re(scanning_r), .raddr(i_r[SAW-1:0]), .rdata(rd_a)
  );

  adsp_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_store_b (
    .clk(clk), .we(ld_we), .waddr(count_r[SAW-1:0]), .wdata(in_sample),
    .re(scanning_r), .raddr(addr_b_full[SAW-1:0]), .rdata(rd_b)
  );

  // Lag store
  logic [31:0] lag_ext;
  logic [63:0] rd_corr;
  assign lag_ext = 32'(in_lag_index);

  adsp_ram #(.WIDTH(64), .DEPTH(MAX_LAGS)) u_corr (
    .clk(clk), .we(cmd.lag_fin && wr_ok), .waddr(t_r[LAW-1:0]), .wdata(cval_r),
    .re(cmd.rd_issue), .raddr(lag_ext[LAW-1:0]), .rdata(rd_corr)
  );

  // Scan pipe: read, deviation, product, accumulate
  logic               v1_r, v2_r, v3_r;
  logic signed [32:0] diff_a, diff_b;
  logic signed [31:0] dev_a, dev_b, dev_a_r, dev_b_r;
  logic               dsat_a, dsat_b;
  logic signed [63:0] prod, prod_r;
  sat64_t             acc_sum;

  always_comb begin
    diff_a = {rd_a[31], rd_a} - {mean_r[31], mean_r};
    diff_b = {rd_b[31], rd_b} - {mean_r[31], mean_r};
    dsat_a = diff_a[32] ^ diff_a[31];
    dsat_b = diff_b[32] ^ diff_b[31];
    dev_a  = dsat_a ? (diff_a[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : diff_a[31:0];
    dev_b  = dsat_b ? (diff_b[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : diff_b[31:0];
  end

  assign prod    = dev_a_r * dev_b_r;
  assign acc_sum = sat_add64(acc_r, prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanning_r <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scanning_r <= 1'b1;
      end else if (scanning_r && (i_r == limit_r - CW'(1))) begin
        scanning_r <= 1'b0;
      end
      v1_r <= scanning_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (cmd.scan_start) begin
      i_r        <= '0;
      // The sum pass starts together with the lag counter reset, so it spans
      // the whole series regardless of the lag left over from the last run.
      limit_r    <= cmd.scan_sum ? count_r : (count_r - CW'(t_r));
      scan_sum_r <= cmd.scan_sum;
      acc_r      <= '0;
    end else begin
      if (scanning_r) begin
        i_r <= i_r + CW'(1);
      end
      if (v3_r) begin
        acc_r <= acc_sum.val;
      end
    end
    if (v1_r) begin
      dev_a_r <= dev_a;
      dev_b_r <= dev_b;
    end
    if (v2_r) begin
      prod_r <= scan_sum_r ? 64'(dev_a_r) : prod;
    end
  end

  // Divider, shared by the mean and every lag value that has sample pairs
  logic               div_busy;
  logic signed [63:0] quotient;

  adsp_div #(.DW(CW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(acc_r),
    .divisor(count_r - CW'(t_r)), .busy(div_busy), .quotient(quotient)
  );

  // Trapezoid integrator
  logic               tv1_r, tv2_r, tv3_r, tv4_r;
  logic signed [63:0] hs_full;
  logic signed [55:0] hs_r;
  logic [9:0]         s10_r;
  logic [TS_W-1:0]    ts_r;
  logic [47:0]        plo_r;
  logic signed [40:0] phi_r;
  logic [25:0]        frac_prod;
  logic [16:0]        frac_r;
  logic signed [72:0] pbig;
  logic signed [63:0] term, term_r;
  logic               term_sat;
  sat64_t             term_sum, integ_sum;

  assign hs_full   = (prev_r >>> 9) + (cval_r >>> 9);
  assign frac_prod = 26'(s10_r) * 26'(ts_r);
  assign pbig      = $signed({phi_r, 32'd0}) + $signed({25'd0, plo_r});
  assign term_sum  = sat_add64(pbig[63:0], 64'(frac_r));
  assign integ_sum = sat_add64(integ_r, term_r);

  always_comb begin
    term_sat = 1'b0;
    term     = term_sum.val;
    if (!pbig[72] && (pbig[71:63] != '0)) begin
      term_sat = 1'b1;
      term     = S64_MAX;
    end else if (pbig[72] && (!(&pbig[71:63]) || (pbig[62:0] == '0))) begin
      term_sat = 1'b1;
      term     = S64_MIN;
    end else if (term_sum.ovf) begin
      term_sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv1_r <= 1'b0;
      tv2_r <= 1'b0;
      tv3_r <= 1'b0;
      tv4_r <= 1'b0;
    end else begin
      tv1_r <= cmd.lag_fin && (t_r != '0);
      tv2_r <= tv1_r;
      tv3_r <= tv2_r;
      tv4_r <= tv3_r;
    end
    if (cmd.lag_fin) begin
      hs_r  <= hs_full[55:0];
      s10_r <= {1'b0, prev_r[8:0]} + {1'b0, cval_r[8:0]};
      ts_r  <= timestep_r;
    end
    if (tv1_r) begin
      plo_r  <= 48'(hs_r[31:0]) * 48'(ts_r);
      phi_r  <= $signed(hs_r[55:32]) * $signed({1'b0, ts_r});
      frac_r <= frac_prod[25:9];
    end
    if (tv3_r) begin
      term_r <= term;
    end
  end

  // Compute-wide registers and saturation flag
  always_comb begin
    sat_nxt = sat_r;
    if (v1_r && !scan_sum_r && (dsat_a || dsat_b)) sat_nxt = 1'b1;
    if (v3_r && acc_sum.ovf) sat_nxt = 1'b1;
    if (tv3_r && term_sat) sat_nxt = 1'b1;
    if (tv4_r && integ_sum.ovf) sat_nxt = 1'b1;
    if (cmd.start_compute) sat_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sat_r   <= 1'b0;
      t_r     <= '0;
    end else begin
      sat_r <= sat_nxt;
      if (ld_we) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.start_compute) begin
        t_r <= '0;
      end else if (cmd.next_lag) begin
        t_r <= t_r + TW'(1);
      end
    end
    if (cmd.start_compute) begin
      mean_r  <= '0;
      integ_r <= '0;
    end else begin
      if (cmd.take_mean) mean_r <= quotient[31:0];
      if (tv4_r) integ_r <= integ_sum.val;
    end
    if (cmd.take_lag) cval_r <= has_pairs ? quotient : 64'sd0;
    if (cmd.lag_fin && (t_r == '0)) var_r <= cval_r;
    if (cmd.next_lag) prev_r <= cval_r;
    if (cmd.rd_issue) lag_r <= in_lag_index;
  end

  // Result register
  logic               out_valid_r;
  kind_t              kind_r;
  logic [LAG_W-1:0]   lag_echo_r;
  logic signed [63:0] corr_r, var_out_r, integral_r;
  status_t            status_r;
  logic               slot_free;
  status_t            sat_status;

  assign slot_free  = !out_valid_r || out_tready;
  assign sat_status = sat_r ? STAT_SATURATED : STAT_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_read || cmd.res_nosamp || cmd.res_stats) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.res_read) begin
      kind_r     <= KIND_CORR;
      lag_echo_r <= lag_r;
      corr_r     <= in_range ? $signed(rd_corr) : 64'sd0;
      var_out_r  <= '0;
      integral_r <= '0;
      status_r   <= in_range ? sat_status : STAT_LAG_RANGE;
    end else if (cmd.res_nosamp || cmd.res_stats) begin
      kind_r     <= KIND_STATS;
      lag_echo_r <= '0;
      corr_r     <= '0;
      var_out_r  <= cmd.res_stats ? var_r : 64'sd0;
      integral_r <= cmd.res_stats ? integ_r : 64'sd0;
      status_r   <= cmd.res_stats ? sat_status : STAT_NO_SAMPLES;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {1'b0, status_r, integral_r, var_out_r, corr_r, lag_echo_r};

  assign stat.no_samples = (count_r == '0);
  assign stat.has_pairs  = has_pairs;
  assign stat.lags_done  = (t_r >= nl_lim);
  assign stat.scan_busy  = scanning_r || v1_r || v2_r || v3_r;
  assign stat.div_busy   = div_busy;
  assign stat.trap_busy  = tv1_r || tv2_r || tv3_r || tv4_r;
  assign stat.slot_free  = slot_free;

endmodule

/* hdl/adsp_ctrl.sv */
// Controller state machine sequencing loads, reads and the statistics passes.
`timescale 1ns / 1ps
module adsp_ctrl
  import adsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [FUNC_W-1:0] in_tuser,
  input  dp_stat_t          stat,
  output dp_cmd_t           cmd
);

  state_t state_r, state_nxt;
  func_t  func;

  assign func = func_t'(in_tuser);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (func)
            FUNC_COMPUTE: state_nxt = stat.no_samples ? S_NOSAMP : S_SUM_SCAN;
            FUNC_READ:    state_nxt = S_RD_RES;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD_RES, S_NOSAMP, S_STATS_RES: begin
        if (stat.slot_free) state_nxt = S_IDLE;
      end
      S_SUM_SCAN:  if (!stat.scan_busy) state_nxt = S_MEAN_DIV;
      S_MEAN_DIV:  if (!stat.div_busy) state_nxt = S_MEAN_TAKE;
      S_MEAN_TAKE: state_nxt = S_LAG_TEST;
      S_LAG_TEST: begin
        priority if (stat.lags_done) state_nxt = S_STATS_RES;
        else if (stat.has_pairs)     state_nxt = S_LAG_SCAN;
        else                         state_nxt = S_LAG_TAKE;
      end
      S_LAG_SCAN:  if (!stat.scan_busy) state_nxt = S_LAG_DIV;
      S_LAG_DIV:   if (!stat.div_busy) state_nxt = S_LAG_TAKE;
      S_LAG_TAKE:  state_nxt = S_LAG_FIN;
      S_LAG_FIN:   state_nxt = S_TRAP;
      S_TRAP:      if (!stat.trap_busy) state_nxt = S_LAG_NEXT;
      S_LAG_NEXT:  state_nxt = S_LAG_TEST;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (func)
            FUNC_LOAD:    cmd.load = 1'b1;
            FUNC_READ:    cmd.rd_issue = 1'b1;
            FUNC_COMPUTE: begin
              cmd.start_compute = 1'b1;
              cmd.scan_start    = !stat.no_samples;
              cmd.scan_sum      = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_RD_RES:    cmd.res_read   = stat.slot_free;
      S_NOSAMP:    cmd.res_nosamp = stat.slot_free;
      S_STATS_RES: cmd.res_stats  = stat.slot_free;
      S_SUM_SCAN, S_LAG_SCAN: cmd.div_start = !stat.scan_busy;
      S_MEAN_TAKE: cmd.take_mean = 1'b1;
      S_LAG_TEST:  cmd.scan_start = !stat.lags_done && stat.has_pairs;
      S_LAG_TAKE:  cmd.take_lag = 1'b1;
      S_LAG_FIN:   cmd.lag_fin = 1'b1;
      S_LAG_NEXT:  cmd.next_lag = 1'b1;
      S_MEAN_DIV, S_LAG_DIV, S_TRAP: ;
    endcase
  end

endmodule

/* hdl/adsp_checker.sv */
// Port-level checker for the autocorrelation block, with its bind statement.
`timescale 1ns / 1ps
`include "autocorrelation_diffusion_stats_defines.svh"
module adsp_checker
  import adsp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  `ADSP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `ADSP_ASSERT_SAME(a_stats_clean, out_tvalid && (out_tuser == KIND_STATS), out_tdata[76:0] == '0, "statistics result carries lag fields")
  `ADSP_ASSERT_SAME(a_read_clean, out_tvalid && (out_tuser == KIND_CORR), out_tdata[204:77] == '0, "read result carries statistics fields")
  `ADSP_ASSERT_SAME(a_range_zero, out_tvalid && (out_tdata[206:205] == STAT_LAG_RANGE), (out_tuser == KIND_CORR) && (out_tdata[76:13] == '0), "out-of-range read is not a zero lag result")

endmodule

bind autocorrelation_diffusion_stats adsp_checker u_adsp_checker (.*);

/* verif/tb_autocorrelation_diffusion_stats.sv */
// Self-checking testbench for the autocorrelation statistics block.
`timescale 1ns / 1ps
module tb_autocorrelation_diffusion_stats;
  import adsp_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_SAMPLES_DEF;
  localparam int unsigned LAG_DEPTH   = MAX_LAGS_DEF;

  // Selector value that the block ignores.
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  // One predicted result transaction, unpacked into its fields.
  typedef struct {
    kind_t             kind;
    logic [LAG_W-1:0]  lag_echo;
    logic signed [63:0] correlation;
    logic signed [63:0] variance;
    logic signed [63:0] integral;
    status_t           status;
  } stats_result_t;

  // The scoreboard keeps its own copy of the sample series, the lag table and
  // the two registers, and turns every accepted transaction into the results
  // the block must produce.
  class acf_scoreboard;
    int                 series[STORE_DEPTH];
    int unsigned        series_len;
    longint             lag_table[LAG_DEPTH];
    bit                 lag_written[LAG_DEPTH];
    bit                 clamped;
    int unsigned        lag_count_reg;
    int unsigned        timestep_reg;
    stats_result_t      pending[$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        computes;

    function new();
      series_len    = 0;
      clamped       = 0;
      lag_count_reg = LAG_COUNT_RST;
      timestep_reg  = TIMESTEP_RST;
      errors        = 0;
      checked       = 0;
      computes      = 0;
      foreach (lag_written[k]) lag_written[k] = 0;
    endfunction

    task report(string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    function int unsigned active_lags();
      return (lag_count_reg < LAG_DEPTH) ? lag_count_reg : LAG_DEPTH;
    endfunction

    function void write_reg(reg_idx_t idx, int unsigned value);
      if (idx == REG_LAG_COUNT) lag_count_reg = value & 16'h3FFF;
      else timestep_reg = value & 16'hFFFF;
    endfunction

    // Add with clamping to the signed 64-bit range; a clamp marks the compute.
    function longint clamp_add(longint a, longint b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
        clamped = 1;
        return s[64] ? S64_MIN : S64_MAX;
      end
      return s[63:0];
    endfunction

    // One trapezoid step: floor((a + b) * ts / 512), done on split operands so
    // that nothing overflows before the final clamp.
    function longint trapezoid_step(longint a, longint b, longint ts);
      longint ah, al, bh, bl, hs, lim;
      if (ts == 0) return 0;
      ah = a / 512; al = a - ah * 512;
      if (al < 0) begin al += 512; ah -= 1; end
      bh = b / 512; bl = b - bh * 512;
      if (bl < 0) begin bl += 512; bh -= 1; end
      hs  = ah + bh;
      lim = S64_MAX / ts;
      if (hs > lim) begin clamped = 1; return S64_MAX; end
      if (hs < -lim) begin clamped = 1; return S64_MIN; end
      return clamp_add(hs * ts, ((al + bl) * ts) / 512);
    endfunction

    function void run_statistics(ref stats_result_t r);
      longint      total, mean, acc, sq, area, d;
      int          dev[];
      int unsigned nl;
      clamped  = 0;
      r.kind   = KIND_STATS;
      r.status = STAT_OK;
      computes++;
      if (series_len == 0) begin
        r.status = STAT_NO_SAMPLES;
        return;
      end
      nl    = active_lags();
      total = 0;
      for (int unsigned i = 0; i < series_len; i++) total += series[i];
      mean = total / longint'(series_len);
      dev  = new[series_len];
      for (int unsigned i = 0; i < series_len; i++) begin
        d = longint'(series[i]) - mean;
        if (d > 64'sh7FFF_FFFF) begin d = 64'sh7FFF_FFFF; clamped = 1; end
        if (d < -64'sh8000_0000) begin d = -64'sh8000_0000; clamped = 1; end
        dev[i] = int'(d);
      end
      for (int unsigned t = 0; t < nl; t++) begin
        acc = 0;
        if (t < series_len) begin
          for (int unsigned i = 0; i + t < series_len; i++)
            acc = clamp_add(acc, longint'(dev[i]) * longint'(dev[i + t]));
          acc = acc / longint'(series_len - t);
        end
        lag_table[t]   = acc;
        lag_written[t] = 1;
      end
      sq = 0;
      for (int unsigned i = 0; i < series_len; i++)
        sq = clamp_add(sq, longint'(dev[i]) * longint'(dev[i]));
      r.variance = sq / longint'(series_len);
      area = 0;
      for (int unsigned t = 0; t + 1 < nl; t++)
        area = clamp_add(area, trapezoid_step(lag_table[t], lag_table[t + 1],
                                              longint'(timestep_reg)));
      r.integral = area;
      r.status   = clamped ? STAT_SATURATED : STAT_OK;
    endfunction

    // Called once per accepted input transaction.
    function void note_input(logic [1:0] func, int sample, int unsigned lag);
      stats_result_t r;
      r = '{KIND_STATS, '0, 0, 0, 0, STAT_OK};
      case (func)
        FUNC_LOAD: begin
          if (series_len < STORE_DEPTH) begin
            series[series_len] = sample;
            series_len++;
          end
        end
        FUNC_COMPUTE: begin
          run_statistics(r);
          pending = {pending, r};
        end
        FUNC_READ: begin
          r.kind     = KIND_CORR;
          r.lag_echo = lag[LAG_W-1:0];
          if (lag < active_lags()) begin
            r.correlation = lag_table[lag];
            r.status      = clamped ? STAT_SATURATED : STAT_OK;
          end else begin
            r.status = STAT_LAG_RANGE;
          end
          pending = {pending, r};
        end
        default: ;
      endcase
    endfunction

    task check_result(stats_result_t got);
      stats_result_t want;
      if (pending.size() == 0) begin
        report("result with no expectation pending");
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.kind != want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.lag_echo != want.lag_echo)
        report($sformatf("lag_echo %0d, expected %0d", got.lag_echo, want.lag_echo));
      if (got.correlation != want.correlation)
        report($sformatf("correlation %0d, expected %0d", got.correlation,
                         want.correlation));
      if (got.variance != want.variance)
        report($sformatf("variance %0d, expected %0d", got.variance, want.variance));
      if (got.integral != want.integral)
        report($sformatf("integral %0d, expected %0d", got.integral, want.integral));
      if (got.status != want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  acf_scoreboard acf = new();
  int unsigned   burst_left = 0;

  always #5 clk = ~clk;

  autocorrelation_diffusion_stats i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Receiver back-pressure. The ready pattern switches between three modes drawn
  // at random: always ready, a coin flip per cycle, or long stalls broken by short windows.
  int unsigned ready_mode = 0;
  int unsigned ready_tick = 0;
  always @(negedge clk) begin
    ready_tick <= ready_tick + 1;
    if (ready_tick % 64 == 0) ready_mode <= $urandom_range(2);
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(1);
      default: out_tready <= ($urandom_range(7) == 0);
    endcase
  end

  // Every result transaction goes to the scoreboard as soon as it is taken.
  always @(posedge clk) begin
    stats_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind        = kind_t'(out_tuser);
      got.lag_echo    = out_tdata[12:0];
      got.correlation = out_tdata[76:13];
      got.variance    = out_tdata[140:77];
      got.integral    = out_tdata[204:141];
      got.status      = status_t'(out_tdata[206:205]);
      acf.check_result(got);
    end
  end

  // Presents one transaction and holds it until the block takes it. With
  // bursts enabled, a random gap with tvalid low follows the end of a burst.
  task automatic send(logic [1:0] func, int sample, int unsigned lag, bit bursty);
    if (bursty && burst_left == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(5)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end else begin
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {3'b000, lag[LAG_W-1:0], sample};
    do @(posedge clk); while (!in_tready);
    acf.note_input(func, sample, lag);
    if (burst_left > 0) burst_left--;
  endtask

  // Drops tvalid and waits until every expected result has come back, then waits
  // further so a trailing load has retired before a register write.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (acf.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    acf.write_reg(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random sample: mostly modest values so the statistics stay unclamped,
  // sometimes the full 32-bit range.
  function automatic int pick_sample();
    if ($urandom_range(19) == 0) return int'($urandom());
    return int'($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
  endfunction

  // Read lag that never lands on a table entry no compute has written.
  function automatic int unsigned pick_lag();
    int unsigned nl, lag;
    nl = acf.active_lags();
    lag = $urandom_range(nl - 1);
    if ($urandom_range(3) != 0 && acf.lag_written[lag]) return lag;
    if (nl < LAG_DEPTH) return $urandom_range(nl, LAG_DEPTH - 1);
    return 0;
  endfunction

  initial begin
    int unsigned nl;
    int          r;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: out-of-range read and compute with an empty series, then an
    // unused selector; then the widest lag range with extreme timestep, and a single lag with a zero timestep.
    send(FUNC_READ, 0, LAG_DEPTH - 1, 0);
    send(FUNC_COMPUTE, 0, 0, 0);
    send(FUNC_SPARE, -1, LAG_DEPTH - 1, 0);
    drain();
    write_reg(REG_LAG_COUNT, LAG_DEPTH);
    write_reg(REG_TIMESTEP, 16'hFFFF);
    send(FUNC_LOAD, 32'sh0001_0000, 0, 0);
    send(FUNC_LOAD, -32'sh0001_0000, 0, 0);
    send(FUNC_LOAD, 3, 0, 0);
    send(FUNC_LOAD, 32'sh0002_8000, 0, 0);
    send(FUNC_LOAD, 0, 0, 0);
    send(FUNC_COMPUTE, 0, 0, 0);
    send(FUNC_READ, 0, LAG_DEPTH - 1, 0);
    send(FUNC_READ, 0, 0, 0);
    send(FUNC_READ, 0, 3, 0);
    send(FUNC_READ, 0, 100, 0);
    drain();
    write_reg(REG_LAG_COUNT, 1);
    write_reg(REG_TIMESTEP, 0);
    send(FUNC_COMPUTE, 0, 0, 0);
    send(FUNC_READ, 0, 0, 0);
    send(FUNC_READ, 0, 1, 0);
    drain();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < 10; phase++) begin
      drain();
      case ($urandom_range(9))
        0:       nl = LAG_DEPTH;
        1:       nl = 1;
        2, 3:    nl = $urandom_range(17, 64);
        default: nl = $urandom_range(2, 16);
      endcase
      write_reg(REG_LAG_COUNT, nl);
      case ($urandom_range(3))
        0:       write_reg(REG_TIMESTEP, 0);
        1:       write_reg(REG_TIMESTEP, 16'hFFFF);
        default: write_reg(REG_TIMESTEP, $urandom_range(16'hFFFF));
      endcase
      for (int k = 0; k < 65; k++) begin
        r = $urandom_range(99);
        if (r < 68)      send(FUNC_LOAD, pick_sample(), $urandom_range(8191), 1);
        else if (r < 80) send(FUNC_COMPUTE, pick_sample(), 0, 1);
        else if (r < 97) send(FUNC_READ, 0, pick_lag(), 1);
        else             send(FUNC_SPARE, pick_sample(), $urandom_range(8191), 1);
      end
    end

    // Extreme samples clamp deviations and sums.
    drain();
    write_reg(REG_LAG_COUNT, 3);
    write_reg(REG_TIMESTEP, 16'hFFFF);
    send(FUNC_LOAD, 32'sh7FFF_FFFF, 0, 0);
    repeat (6) send(FUNC_LOAD, 32'sh8000_0000, 0, 0);
    send(FUNC_LOAD, 32'sh7FFF_FFFF, 0, 0);
    send(FUNC_COMPUTE, 0, 0, 0);
    send(FUNC_READ, 0, 2, 0);
    send(FUNC_READ, 0, 3, 0);
    drain();
    repeat (20) @(posedge clk);

    $display("Checked %0d results from %0d statistics runs; series ended at %0d samples.",
             acf.checked, acf.computes, acf.series_len);
    if (acf.errors == 0 && acf.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", acf.errors,
               acf.pending.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    repeat (40) #100_000_000;
    $display("Watchdog expired with %0d results outstanding.", acf.pending.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
